### rtl/aeg_pkg.sv
// ----------------------------------------------------------------------------
// aeg_pkg
// Shared types and constants for the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
package aeg_pkg;

   localparam int unsigned SAMPLE_W = 24;
   localparam int unsigned LEVEL_W  = 25;
   localparam int unsigned THRESH_W = 23;
   localparam int unsigned STAGE_W  = 3;
   localparam int unsigned ADDR_W   = 5;
   localparam int unsigned DATA_W   = 32;

   // 1.0 in Q1.24
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = 25'h100_0000;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_GATE_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_ATTACK_STEP    = 3'd1;
   localparam logic [2:0] REG_DECAY_STEP     = 3'd2;
   localparam logic [2:0] REG_SUSTAIN_LEVEL  = 3'd3;
   localparam logic [2:0] REG_RELEASE_STEP   = 3'd4;

   // reset values
   localparam logic [THRESH_W-1:0] RST_GATE_THRESHOLD = 23'd8389;
   localparam logic [LEVEL_W-1:0]  RST_ATTACK_STEP    = 25'd38044;
   localparam logic [LEVEL_W-1:0]  RST_DECAY_STEP     = 25'd1141;
   localparam logic [LEVEL_W-1:0]  RST_SUSTAIN_LEVEL  = 25'd11744051;
   localparam logic [LEVEL_W-1:0]  RST_RELEASE_STEP   = 25'd761;

   typedef enum logic [STAGE_W-1:0] {
      ST_IDLE    = 3'd0,
      ST_ATTACK  = 3'd1,
      ST_DECAY   = 3'd2,
      ST_SUSTAIN = 3'd3,
      ST_RELEASE = 3'd4
   } stage_type;

   typedef struct packed {
      logic [THRESH_W-1:0] gate_threshold;
      logic [LEVEL_W-1:0]  attack_step;
      logic [LEVEL_W-1:0]  decay_step;
      logic [LEVEL_W-1:0]  sustain_level;
      logic [LEVEL_W-1:0]  release_step;
   } cfg_type;

   typedef struct packed {
      stage_type          stage;
      logic [LEVEL_W-1:0] level;
   } env_type;

endpackage

### rtl/aeg_req_if.sv
// ----------------------------------------------------------------------------
// aeg_req_if
// Sample input channel: valid/ready handshake with one signed Q1.23 sample.
// ----------------------------------------------------------------------------
interface aeg_req_if
   import aeg_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface

### rtl/aeg_rsp_if.sv
// ----------------------------------------------------------------------------
// aeg_rsp_if
// Result channel: scaled sample, envelope level and stage.
// ----------------------------------------------------------------------------
interface aeg_rsp_if
   import aeg_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_sample;
   logic [LEVEL_W-1:0]         env_level;
   logic [STAGE_W-1:0]         env_stage;

   modport source (output valid, output out_sample, output env_level, output env_stage,
                   input ready);
   modport sink   (input valid, input out_sample, input env_level, input env_stage,
                   output ready);
endinterface

### rtl/adsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Linear ADSR envelope applied to a sample stream, gate taken from the sample.
// ----------------------------------------------------------------------------
// One sample is accepted every clock cycle while results are taken, and one
// result leaves per sample, in order. The envelope state is updated at the
// sample's transfer edge (gate compare, stage change, one level add or
// subtract with clamp); in the next cycle the sample is scaled by the new
// level in a 24 x 25 bit multiplier into the output register. Stalls on the
// result side back up through the two stages, and a new sample is taken
// in the same cycle that a waiting result is transferred. The user must
// write settings through the APB port only while no sample is in flight;
// the block itself does not enforce this. Step registers captured at a
// stage change keep their value until the next change.
// ----------------------------------------------------------------------------
module adsr_envelope_generator
   import aeg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   aeg_req_if.sink           req_chan,
   aeg_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;
   env_type env;

   // pipeline control
   logic mid_v_ff,  mid_v_in;
   logic out_v_ff,  out_v_in;
   logic out_free;          // output register can take new data
   logic mid_free;          // middle stage can take a new sample
   logic req_xfer;
   logic mid_move;

   // payload registers
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic [LEVEL_W-1:0]         env_level_ff;
   stage_type                  env_stage_ff;

   logic signed [SAMPLE_W+LEVEL_W:0] product;

   aeg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // envelope state advances on every sample transfer
   aeg_envelope u_env (
      .clock     (clock),
      .reset     (reset),
      .update    (req_xfer),
      .in_sample (req_chan.in_sample),
      .cfg       (cfg),
      .env       (env)
   );

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign mid_move = mid_v_ff && out_free;
   assign mid_free = !mid_v_ff || out_free;
   assign req_chan.ready = mid_free;
   assign req_xfer = req_chan.valid && mid_free;

   assign mid_v_in = req_xfer || (mid_v_ff && !out_free);
   assign out_v_in = mid_move || (out_v_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         mid_v_ff <= mid_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // sample held next to the envelope state it produced
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sample_ff <= req_chan.in_sample;
      end
   end

   // floor(sample * level / 2^24): arithmetic shift of the full product
   assign product       = sample_ff * $signed({1'b0, env.level});
   assign out_sample_in = product[SAMPLE_W+LEVEL_W-2:LEVEL_W-1];

   always_ff @(posedge clock) begin
      if (mid_move) begin
         out_sample_ff <= out_sample_in;
         env_level_ff  <= env.level;
         env_stage_ff  <= env.stage;
      end
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.out_sample = out_sample_ff;
   assign rsp_chan.env_level  = env_level_ff;
   assign rsp_chan.env_stage  = env_stage_ff;

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> mid_v_ff && out_v_ff && !rsp_chan.ready)
      else $error("input stalled with a free stage");

   a_xfer_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> mid_v_ff)
      else $error("accepted sample lost in middle stage");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_v_ff) |-> $past(mid_v_ff))
      else $error("result appeared without a sample in flight");

endmodule

### rtl/aeg_csr.sv
// ----------------------------------------------------------------------------
// aeg_csr
// APB-style register file holding threshold, step and sustain settings.
// ----------------------------------------------------------------------------
module aeg_csr
   import aeg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GATE_THRESHOLD: cfg_in.gate_threshold = csr_pwdata[THRESH_W-1:0];
            REG_ATTACK_STEP:    cfg_in.attack_step    = csr_pwdata[LEVEL_W-1:0];
            REG_DECAY_STEP:     cfg_in.decay_step     = csr_pwdata[LEVEL_W-1:0];
            REG_SUSTAIN_LEVEL:  cfg_in.sustain_level  = csr_pwdata[LEVEL_W-1:0];
            REG_RELEASE_STEP:   cfg_in.release_step   = csr_pwdata[LEVEL_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_threshold <= RST_GATE_THRESHOLD;
         cfg_ff.attack_step    <= RST_ATTACK_STEP;
         cfg_ff.decay_step     <= RST_DECAY_STEP;
         cfg_ff.sustain_level  <= RST_SUSTAIN_LEVEL;
         cfg_ff.release_step   <= RST_RELEASE_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GATE_THRESHOLD: csr_prdata = {{(DATA_W-THRESH_W){1'b0}}, cfg_ff.gate_threshold};
         REG_ATTACK_STEP:    csr_prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_ff.attack_step};
         REG_DECAY_STEP:     csr_prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_ff.decay_step};
         REG_SUSTAIN_LEVEL:  csr_prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_ff.sustain_level};
         REG_RELEASE_STEP:   csr_prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_ff.release_step};
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/aeg_envelope.sv
// ----------------------------------------------------------------------------
// aeg_envelope
// Envelope state (stage, level, active step) and its per-sample update.
// ----------------------------------------------------------------------------
module aeg_envelope
   import aeg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       update,
   input  logic signed [SAMPLE_W-1:0] in_sample,
   input  cfg_type                    cfg,
   output env_type                    env
);

   stage_type          stage_ff, stage_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [LEVEL_W-1:0] step_ff,  step_in;

   logic                    gate;
   logic [LEVEL_W-1:0]      sus_clamped;
   stage_type               stage_trig;
   logic [LEVEL_W-1:0]      level_trig;
   logic [LEVEL_W-1:0]      step_trig;
   logic [LEVEL_W:0]        sum;
   logic signed [LEVEL_W+1:0] diff;

   // sample is compared as signed against a non-negative threshold
   assign gate = in_sample > $signed({1'b0, cfg.gate_threshold});
   assign sus_clamped = (cfg.sustain_level > LEVEL_ONE) ? LEVEL_ONE : cfg.sustain_level;

   // next state
   always_comb begin
      stage_trig = stage_ff;
      level_trig = level_ff;
      step_trig  = step_ff;
      if (gate && stage_ff == ST_IDLE) begin
         stage_trig = ST_ATTACK;
         level_trig = '0;
         step_trig  = cfg.attack_step;
      end else if (!gate && stage_ff != ST_IDLE && stage_ff != ST_RELEASE) begin
         stage_trig = ST_RELEASE;
         step_trig  = cfg.release_step;
      end

      sum  = {1'b0, level_trig} + {1'b0, step_trig};
      diff = $signed({2'b00, level_trig}) - $signed({2'b00, step_trig});

      stage_in = stage_trig;
      level_in = level_trig;
      step_in  = step_trig;
      unique case (stage_trig)
         ST_ATTACK: begin
            if (sum >= {1'b0, LEVEL_ONE}) begin
               level_in = LEVEL_ONE;
               stage_in = ST_DECAY;
               step_in  = cfg.decay_step;
            end else begin
               level_in = sum[LEVEL_W-1:0];
            end
         end
         ST_DECAY: begin
            if (diff <= $signed({2'b00, sus_clamped})) begin
               level_in = sus_clamped;
               stage_in = ST_SUSTAIN;
            end else begin
               level_in = diff[LEVEL_W-1:0];
            end
         end
         ST_SUSTAIN: level_in = sus_clamped;
         ST_RELEASE: begin
            if (diff <= 0) begin
               level_in = '0;
               stage_in = ST_IDLE;
            end else begin
               level_in = diff[LEVEL_W-1:0];
            end
         end
         default: begin
            level_in = '0;
            stage_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_IDLE;
         level_ff <= '0;
         step_ff  <= '0;
      end else if (update) begin
         stage_ff <= stage_in;
         level_ff <= level_in;
         step_ff  <= step_in;
      end
   end

   // outputs
   always_comb begin
      env.stage = stage_ff;
      env.level = level_ff;
   end

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_ONE)
      else $error("envelope level above 1.0");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      stage_ff == ST_IDLE |-> level_ff == '0)
      else $error("idle stage with nonzero level");

   a_sustain_exit: assert property (@(posedge clock) disable iff (reset)
      $past(stage_ff) == ST_SUSTAIN |-> stage_ff != ST_ATTACK && stage_ff != ST_DECAY)
      else $error("sustain went back to attack or decay");

endmodule

### bench/adsr_envelope_generator_test.sv
// ----------------------------------------------------------------------------
// adsr_envelope_generator_test
// Self-checking bench for the linear ADSR envelope generator: a clocked
// driver and monitor around the block, an in-bench envelope predictor, and
// APB register writes between phases of directed and note-shaped stimulus.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_test;
   import aeg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned PHASES      = 10;
   localparam int unsigned PHASE_ITEMS = 82;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7F_FFFF;
   localparam logic [LEVEL_W-1:0]  FIELD_MAX  = 25'h1FF_FFFF;

   // one expected result, field by field
   typedef struct {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic [LEVEL_W-1:0]         env_level;
      logic [STAGE_W-1:0]         env_stage;
   } scaled_result_type;

   logic clock;
   logic reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   aeg_req_if req_chan ();
   aeg_rsp_if rsp_chan ();

   adsr_envelope_generator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // samples waiting for the driver, expected results waiting for the monitor
   logic signed [SAMPLE_W-1:0] sample_queue[$];
   scaled_result_type          envelope_results[$];

   // register mirror and envelope state of the predictor
   cfg_type   cfg_shadow;
   stage_type env_stage_q;
   longint    env_level_q;
   longint    env_step_q;

   int unsigned items_total;
   int unsigned results_seen;
   int unsigned fail_count;
   int unsigned cycle_count;

   bit          req_fire;      // input transfer at the last rising edge
   bit          req_idle_on;
   bit          rsp_idle_on;
   int unsigned req_gap;
   int unsigned rsp_gap;
   int unsigned hold_ask;      // bumped by stimulus to request a long hold-off
   int unsigned hold_seen;
   int unsigned hold_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Gap length: mostly back to back, some short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Step register value: mostly a fraction of 1.0 so stages turn over within
   // a note, sometimes zero, sometimes anything the field holds.
   function automatic logic [LEVEL_W-1:0] rand_step();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return LEVEL_W'($urandom());
      return LEVEL_W'(int'(LEVEL_ONE) / $urandom_range(1, 40));
   endfunction

   // Sample that opens or closes the gate under the current threshold.
   function automatic logic signed [SAMPLE_W-1:0] note_sample(input bit gate_on);
      int unsigned thr;
      thr = cfg_shadow.gate_threshold;
      if (gate_on && thr < SAMPLE_MAX)
         return SAMPLE_W'($urandom_range(thr + 1, SAMPLE_MAX));
      if ($urandom_range(0, 1) == 0)
         return {1'b1, 23'($urandom())};
      return SAMPLE_W'($urandom_range(0, thr));
   endfunction

   function automatic void push_sample(input logic signed [SAMPLE_W-1:0] smp);
      sample_queue = {sample_queue, smp};
      items_total++;
   endfunction

   // Envelope predictor: gate transition first, then one linear step, then
   // the sample scaled by the new level (floor of the product over 2^24).
   function automatic void advance_envelope(input logic signed [SAMPLE_W-1:0] smp);
      longint            s;
      longint            sus;
      longint            prod;
      bit                gate_on;
      scaled_result_type r;
      s       = smp;
      gate_on = s > longint'(cfg_shadow.gate_threshold);
      sus     = (cfg_shadow.sustain_level > LEVEL_ONE) ? longint'(LEVEL_ONE)
                                                        : longint'(cfg_shadow.sustain_level);
      if (gate_on && env_stage_q == ST_IDLE) begin
         env_stage_q = ST_ATTACK;
         env_level_q = 0;
         env_step_q  = cfg_shadow.attack_step;
      end else if (!gate_on && env_stage_q != ST_IDLE && env_stage_q != ST_RELEASE) begin
         // gate-off from attack, decay or sustain; release is never retriggered
         env_stage_q = ST_RELEASE;
         env_step_q  = cfg_shadow.release_step;
      end
      case (env_stage_q)
         ST_ATTACK: begin
            env_level_q += env_step_q;
            if (env_level_q >= longint'(LEVEL_ONE)) begin
               env_level_q = LEVEL_ONE;
               env_stage_q = ST_DECAY;
               env_step_q  = cfg_shadow.decay_step;
            end
         end
         ST_DECAY: begin
            env_level_q -= env_step_q;
            if (env_level_q <= sus) begin
               env_level_q = sus;
               env_stage_q = ST_SUSTAIN;
            end
         end
         ST_SUSTAIN: env_level_q = sus;
         ST_RELEASE: begin
            env_level_q -= env_step_q;
            if (env_level_q <= 0) begin
               env_level_q = 0;
               env_stage_q = ST_IDLE;
            end
         end
         default: begin
            env_stage_q = ST_IDLE;
            env_level_q = 0;
         end
      endcase
      prod         = s * env_level_q;
      r.out_sample = SAMPLE_W'(prod >>> 24);
      r.env_level  = env_level_q[LEVEL_W-1:0];
      r.env_stage  = env_stage_q;
      envelope_results = {envelope_results, r};
   endfunction

   function automatic void check_envelope_output();
      scaled_result_type r;
      results_seen++;
      if (envelope_results.size() == 0) begin
         $display("%0t: unexpected result out_sample=%0d env_level=%0d env_stage=%0d",
                  $time, rsp_chan.out_sample, rsp_chan.env_level, rsp_chan.env_stage);
         fail_count++;
         return;
      end
      r = envelope_results.pop_front();
      if (rsp_chan.out_sample !== r.out_sample) begin
         $display("%0t: out_sample expected %0d actual %0d",
                  $time, r.out_sample, rsp_chan.out_sample);
         fail_count++;
      end
      if (rsp_chan.env_level !== r.env_level) begin
         $display("%0t: env_level expected %0d actual %0d",
                  $time, r.env_level, rsp_chan.env_level);
         fail_count++;
      end
      if (rsp_chan.env_stage !== r.env_stage) begin
         $display("%0t: env_stage expected %0d actual %0d",
                  $time, r.env_stage, rsp_chan.env_stage);
         fail_count++;
      end
   endfunction

   // APB write: setup cycle, then access cycle; the register takes the value
   // at the rising edge with penable and pready high.
   task automatic csr_write(input logic [2:0] index, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (index)
         REG_GATE_THRESHOLD: cfg_shadow.gate_threshold = value[THRESH_W-1:0];
         REG_ATTACK_STEP:    cfg_shadow.attack_step    = value[LEVEL_W-1:0];
         REG_DECAY_STEP:     cfg_shadow.decay_step     = value[LEVEL_W-1:0];
         REG_SUSTAIN_LEVEL:  cfg_shadow.sustain_level  = value[LEVEL_W-1:0];
         REG_RELEASE_STEP:   cfg_shadow.release_step   = value[LEVEL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [THRESH_W-1:0] thr,
                                 input logic [LEVEL_W-1:0] atk,
                                 input logic [LEVEL_W-1:0] dec,
                                 input logic [LEVEL_W-1:0] sus,
                                 input logic [LEVEL_W-1:0] rel);
      csr_write(REG_GATE_THRESHOLD, DATA_W'(thr));
      csr_write(REG_ATTACK_STEP,    DATA_W'(atk));
      csr_write(REG_DECAY_STEP,     DATA_W'(dec));
      csr_write(REG_SUSTAIN_LEVEL,  DATA_W'(sus));
      csr_write(REG_RELEASE_STEP,   DATA_W'(rel));
   endtask

   // Sender pause: every queued sample has come back as a result, then a margin
   // for the two-stage pipe before registers are touched.
   task automatic wait_drained();
      while (results_seen < items_total) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Driver: a new sample goes out once the previous one has transferred
   // (or the channel was idle), after any gap that was drawn.
   always @(negedge clock) begin
      logic                       next_valid;
      logic signed [SAMPLE_W-1:0] next_sample;
      next_valid  = req_chan.valid;
      next_sample = req_chan.in_sample;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_chan.valid || req_fire) begin
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (sample_queue.size() > 0) begin
            next_sample = sample_queue.pop_front();
            next_valid  = 1'b1;
            if (req_idle_on) req_gap = pick_gap();
         end
      end
      req_chan.valid     <= next_valid;
      req_chan.in_sample <= next_sample;
   end

   // Receiver: random stalls, plus the long hold-off counted here on request.
   always @(negedge clock) begin
      if (hold_seen != hold_ask) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (rsp_idle_on && $urandom_range(0, 3) == 0) rsp_gap = pick_gap();
      end
   end

   // Monitor: predict on each input transfer, check on each result transfer.
   // A result always trails its own sample through the middle and output
   // registers, so the order of the two calls within one edge does not matter.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) advance_envelope(req_chan.in_sample);
         if (rsp_chan.valid && rsp_chan.ready) check_envelope_output();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("adsr_envelope_generator: mismatch");
         $finish;
      end
   end

   initial begin
      int unsigned n;
      int unsigned on_len;
      int unsigned off_len;
      int unsigned k;
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_chan.valid     = 1'b0;
      req_chan.in_sample = '0;
      rsp_chan.ready     = 1'b0;
      cfg_shadow = '{RST_GATE_THRESHOLD, RST_ATTACK_STEP, RST_DECAY_STEP,
                     RST_SUSTAIN_LEVEL, RST_RELEASE_STEP};
      env_stage_q = ST_IDLE;
      env_level_q = 0;
      env_step_q  = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, reset settings: silence, gate-on from idle, gate-off in
      // attack, gate-on during release (no retrigger), sample equal to the
      // threshold, and the sample extremes.
      push_sample('0);
      push_sample(SAMPLE_MAX);
      push_sample(24'sh80_0000);
      push_sample(24'sd8390);
      push_sample(24'sd8389);
      push_sample(-24'sd1);
      push_sample(24'sd1);
      wait_drained();

      // Directed, steps at full width: attack overshoots and clamps, decay
      // falls straight to a zero sustain, release empties in one step.
      write_settings('0, FIELD_MAX, FIELD_MAX, '0, FIELD_MAX);
      push_sample(24'sd1);
      push_sample(24'sd1);
      push_sample(SAMPLE_MAX);
      push_sample(24'sh40_0000);
      push_sample('0);
      push_sample(24'sh80_0000);
      wait_drained();

      // Directed, sustain above one (used as one) and a unit decay step.
      write_settings(THRESH_W'(100), LEVEL_ONE, 25'd1, FIELD_MAX, 25'd1);
      push_sample(24'sd101);
      push_sample(SAMPLE_MAX);
      push_sample(24'sh80_0000);
      push_sample(-24'sd4321);
      push_sample(24'sd100);
      push_sample(24'sh12_3456);
      push_sample(24'sd100);
      wait_drained();

      // Random phases of notes: a run of gate-on samples, then gate-off, with
      // about one in eight samples drawn from the whole range.
      for (int unsigned p = 0; p < PHASES; p++) begin
         case (p)
            0: write_settings(THRESH_W'(SAMPLE_MAX), FIELD_MAX, FIELD_MAX, FIELD_MAX,
                              FIELD_MAX);
            1: write_settings('0, '0, '0, FIELD_MAX, '0);
            2: write_settings('0, 25'd1, 25'd1, LEVEL_ONE, 25'd1);
            default: write_settings(($urandom_range(0, 3) == 0)
                                       ? THRESH_W'($urandom())
                                       : THRESH_W'($urandom_range(0, 24'h04_0000)),
                                    rand_step(), rand_step(),
                                    ($urandom_range(0, 5) == 0)
                                       ? LEVEL_W'($urandom())
                                       : LEVEL_W'($urandom_range(0, LEVEL_ONE)),
                                    rand_step());
         endcase
         req_idle_on = (p % 3) != 1;
         rsp_idle_on = (p % 4) != 2;
         if (p == 6) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         n = 0;
         while (n < PHASE_ITEMS) begin
            on_len  = $urandom_range(1, 60);
            off_len = $urandom_range(1, 25);
            for (k = 0; k < on_len + off_len; k++) begin
               if ($urandom_range(0, 7) == 0)
                  push_sample(SAMPLE_W'($urandom()));
               else
                  push_sample(note_sample(k < on_len));
            end
            n += on_len + off_len;
         end
         // long receiver hold-off while the sender keeps offering samples
         if (p == 4 || p == 8) hold_ask++;
         wait_drained();
      end

      if (envelope_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, envelope_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("adsr_envelope_generator: match");
      else
         $display("adsr_envelope_generator: mismatch");
      $finish;
   end

endmodule
